>>> hdl/assert_macros.svh
// Assertion macros shared by the date adder modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/dad_pkg.sv
// Types, constants and calendar functions for the date adder.
// No dependencies; used by dad_ctrl, dad_dp and date_add_days.
package dad_pkg;

	localparam logic [15:0] DAYS_RESET  = 16'd45;
	localparam logic [12:0] DIV100_MUL  = 13'd5243;
	localparam int          DIV100_SHIFT = 19;
	localparam logic        REG_DAYS    = 1'b0;

	typedef struct packed {
		logic [4:0]  day_in;
		logic [3:0]  month_in;
		logic [13:0] year_in;
	} date_t;

	typedef struct packed {
		logic [4:0]  day_out;
		logic [3:0]  month_out;
		logic [13:0] year_out;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RES,
		S_DOY,
		S_SPLIT,
		S_YEAR,
		S_MONTH,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic res;
		logic doy;
		logic split;
		logic year;
		logic month;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic fits;
		logic more_years;
		logic month_done;
		logic out_free;
	} dp_sts_t;

	// Leap rule from the year's low bits and its residues by 100 and 400.
	function automatic logic is_leap(input logic [1:0] y_lo, input logic [6:0] r100,
			input logic [1:0] c4);
		return ((y_lo == 2'd0) && (r100 != 7'd0)) || ((r100 == 7'd0) && (c4 == 2'd0));
	endfunction

	function automatic logic [8:0] year_len(input logic leap);
		return leap ? 9'd366 : 9'd365;
	endfunction

	// Days in all months before month m, common year.
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] n;
		case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd2:                     n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:  n = 5'd30;
			default:                  n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

>>> hdl/date_add_days.sv
// Top level of the date adder: configuration register, sequencer and datapath.
// Depends on dad_pkg, dad_ctrl and dad_dp.
//
//   Channel   Direction  Handshake                    Beat contents
//   date      in         date_valid / date_ready      day_in, month_in, year_in
//   result    out        result_valid / result_ready  day_out, month_out, year_out
//   config    in (APB)   psel, penable, pwrite        days_to_add at byte address 0
//
// A beat passes through the residue, day-of-year and split steps, then the year loop when the sum
// leaves its year, skipping up to about 180 whole years for 65535 days, then walks up to 11 months
// in the final year before the output step.
// The next date beat can be taken in the cycle after the result is loaded, even before the result is taken.
// Reset clears the sequencer and result valid flag and sets days_to_add to 45.
// A stalled result holds the sequencer in its output step until the register frees up.

module date_add_days (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              date_valid,
	output logic              date_ready,
	input  dad_pkg::date_t    date,
	output logic              result_valid,
	input  logic              result_ready,
	output dad_pkg::result_t  result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [15:0]       days_q;
	dad_pkg::dp_cmd_t  cmd;
	dad_pkg::dp_sts_t  sts;

	// The only register sits at word 0; bit 2 of the byte address selects the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			days_q <= dad_pkg::DAYS_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == dad_pkg::REG_DAYS)) begin
			days_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == dad_pkg::REG_DAYS) ? {16'd0, days_q} : 32'd0;

	dad_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.date_valid (date_valid),
		.date_ready (date_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	dad_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.date         (date),
		.days_to_add  (days_q),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

>>> hdl/dad_ctrl.sv
// Sequencer for the date adder: walks one date through the datapath steps.
// Depends on dad_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dad_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             date_valid,
	output logic             date_ready,
	input  dad_pkg::dp_sts_t sts,
	output dad_pkg::dp_cmd_t cmd
);

	dad_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dad_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dad_pkg::S_IDLE:  if (date_valid) state_d = dad_pkg::S_RES;
			dad_pkg::S_RES:   state_d = dad_pkg::S_DOY;
			dad_pkg::S_DOY:   state_d = dad_pkg::S_SPLIT;
			dad_pkg::S_SPLIT: state_d = sts.fits ? dad_pkg::S_MONTH : dad_pkg::S_YEAR;
			dad_pkg::S_YEAR:  if (!sts.more_years) state_d = dad_pkg::S_MONTH;
			dad_pkg::S_MONTH: if (sts.month_done) state_d = dad_pkg::S_OUT;
			dad_pkg::S_OUT:   if (sts.out_free) state_d = dad_pkg::S_IDLE;
			default:          state_d = dad_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		date_ready = 1'b0;
		unique case (state_q)
			dad_pkg::S_IDLE: begin
				date_ready = 1'b1;
				cmd.load   = date_valid;
			end
			dad_pkg::S_RES:   cmd.res      = 1'b1;
			dad_pkg::S_DOY:   cmd.doy      = 1'b1;
			dad_pkg::S_SPLIT: cmd.split    = 1'b1;
			dad_pkg::S_YEAR:  cmd.year     = 1'b1;
			dad_pkg::S_MONTH: cmd.month    = 1'b1;
			dad_pkg::S_OUT:   cmd.out_load = sts.out_free;
			default: begin
				cmd        = '0;
				date_ready = 1'b0;
			end
		endcase
	end

	`ASSERT_NXT(a_out_to_idle, clk, arst_n, state_q == dad_pkg::S_OUT && sts.out_free,
		state_q == dad_pkg::S_IDLE)
	`ASSERT_NXT(a_load_starts, clk, arst_n, cmd.load, state_q == dad_pkg::S_RES && !date_ready)
	`ASSERT_IMP(a_ready_idle, clk, arst_n, date_ready, state_q == dad_pkg::S_IDLE)

endmodule

>>> hdl/dad_dp.sv
// Datapath of the date adder: date registers, year residues, day counter, result register.
// Depends on dad_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dad_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  dad_pkg::dp_cmd_t  cmd,
	output dad_pkg::dp_sts_t  sts,
	input  dad_pkg::date_t    date,
	input  logic [15:0]       days_to_add,
	output logic              result_valid,
	input  logic              result_ready,
	output dad_pkg::result_t  result
);

	logic [4:0]  d_q;
	logic [3:0]  m_q;
	logic [14:0] y_q;
	logic [7:0]  q_q;
	logic [6:0]  r100_q;
	logic [1:0]  c4_q;
	logic [15:0] x_q;
	logic [16:0] cnt_q;
	logic        result_valid_q;
	dad_pkg::result_t result_q;

	logic [26:0] prod;
	logic [13:0] q100;
	logic        leap;
	logic [8:0]  ylen;
	logic [8:0]  rem;
	logic [4:0]  mlen;
	logic        fits;
	logic        more_years;
	logic        month_done;

	// Year / 100 by reciprocal multiply; exact for every 14-bit year.
	assign prod = 27'(date.year_in) * 27'(dad_pkg::DIV100_MUL);
	assign q100 = {q_q, 6'd0} + {1'b0, q_q, 5'd0} + {4'd0, q_q, 2'd0};

	assign leap       = dad_pkg::is_leap(y_q[1:0], r100_q, c4_q);
	assign ylen       = dad_pkg::year_len(leap);
	assign rem        = ylen - cnt_q[8:0];
	assign fits       = {1'b0, x_q} <= {8'd0, rem};
	assign more_years = cnt_q > {8'd0, ylen};
	assign mlen       = dad_pkg::month_len(m_q, leap);
	assign month_done = (m_q == 4'd12) || (cnt_q <= {12'd0, mlen});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q   <= (date.day_in == 5'd0) ? 5'd1 : date.day_in;
			m_q   <= (date.month_in == 4'd0) ? 4'd1 :
				(date.month_in > 4'd12) ? 4'd12 : date.month_in;
			y_q   <= {1'b0, date.year_in};
			q_q   <= prod[26:dad_pkg::DIV100_SHIFT];
			x_q   <= days_to_add;
		end
		if (cmd.res) begin
			r100_q <= 7'(y_q[13:0] - q100);
			c4_q   <= q_q[1:0];
		end
		if (cmd.doy) begin
			cnt_q <= 17'(d_q) + 17'(dad_pkg::days_before(m_q))
				+ 17'(leap && (m_q > 4'd2));
		end
		if (cmd.split) begin
			m_q <= 4'd1;
			if (fits) begin
				cnt_q <= cnt_q + 17'(x_q);
			end else begin
				cnt_q <= 17'(x_q) - 17'(rem);
			end
		end
		if (cmd.year && more_years) begin
			cnt_q <= cnt_q - 17'(ylen);
		end
		// Year advance keeps the residues by 100 and 400 in step.
		if ((cmd.split && !fits) || (cmd.year && more_years)) begin
			y_q <= y_q + 15'd1;
			if (r100_q == 7'd99) begin
				r100_q <= 7'd0;
				c4_q   <= c4_q + 2'd1;
			end else begin
				r100_q <= r100_q + 7'd1;
			end
		end
		if (cmd.month && !month_done) begin
			cnt_q <= cnt_q - 17'(mlen);
			m_q   <= m_q + 4'd1;
		end
		if (cmd.out_load) begin
			result_q.day_out   <= cnt_q[4:0];
			result_q.month_out <= m_q;
			result_q.year_out  <= y_q[13:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid   = result_valid_q;
	assign result         = result_q;
	assign sts.fits       = fits;
	assign sts.more_years = more_years;
	assign sts.month_done = month_done;
	assign sts.out_free   = !result_valid_q || result_ready;

	`ASSERT_NXT(a_year_step, clk, arst_n, cmd.year && more_years,
		y_q == $past(y_q) + 15'd1)
	`ASSERT_IMP(a_month_range, clk, arst_n, cmd.month, m_q >= 4'd1 && m_q <= 4'd12)
	`ASSERT_IMP(a_res_range, clk, arst_n, cmd.year || cmd.month, r100_q < 7'd100)

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for date_add_days: random and directed dates against a day offset.
// Depends on dad_pkg and the date_add_days RTL; needs no other files.

module tb_top;

	// Longest stretch without any beat or register access before the run is declared hung.
	localparam int unsigned STALL_LIMIT = 4000;
	// Cycles to watch after the last result for anything the block should not send.
	localparam int unsigned TAIL_CYCLES = 300;
	localparam int unsigned PHASES      = 14;
	localparam int unsigned PER_PHASE   = 118;
	localparam logic [2:0]  DAYS_ADDR   = {dad_pkg::REG_DAYS, 2'b00};

	// A date waiting to be sent; hold marks a date that goes out only once every
	// earlier result has come back.
	typedef struct {
		dad_pkg::date_t d;
		bit             hold;
	} pend_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             date_valid = 1'b0;
	logic             date_ready;
	dad_pkg::date_t   date = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	dad_pkg::result_t result;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [2:0]       paddr = '0;
	logic [31:0]      pwdata = '0;
	logic [31:0]      prdata;
	logic             pready;

	pend_t            pending_dates [$];
	dad_pkg::result_t expected_results [$];
	logic [15:0]      days_cfg = dad_pkg::DAYS_RESET;
	int unsigned      outstanding = 0;
	int unsigned      dates_checked = 0;
	int unsigned      fails = 0;
	int unsigned      idle_cycles = 0;
	int unsigned      gap_left = 0;
	int unsigned      stall_left = 0;
	bit               date_taken = 1'b0;
	bit               calm = 1'b0;
	dad_pkg::result_t want;

	date_add_days uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.date_valid   (date_valid),
		.date_ready   (date_ready),
		.date         (date),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Calendar predictor
	// ------------------------------------------------------------------

	// The leap test runs on the full year, also past the 14-bit wrap.
	function automatic bit leap(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned year_days(input int unsigned y);
		return leap(y) ? 366 : 365;
	endfunction

	function automatic int unsigned mon_days(input int unsigned m, input int unsigned y);
		int unsigned n;
		case (m)
			2:             n = leap(y) ? 29 : 28;
			4, 6, 9, 11:   n = 30;
			default:       n = 31;
		endcase
		return n;
	endfunction

	// Moves one date forward by the given number of days.
	function automatic dad_pkg::result_t shift_date(input dad_pkg::date_t d,
			input logic [15:0] offset);
		int unsigned dd, mm, yy, left, yday, room, k;
		dad_pkg::result_t r;
		dd = 32'(d.day_in);
		mm = 32'(d.month_in);
		yy = 32'(d.year_in);
		left = 32'(offset);
		// Day zero counts as the first, month zero as January, months past 12 as December.
		if (dd == 0)
			dd = 1;
		if (mm == 0)
			mm = 1;
		if (mm > 12)
			mm = 12;
		// A day past the month end simply runs on into the next month here.
		yday = dd;
		for (k = 1; k < mm; k++)
			yday += mon_days(k, yy);
		room = year_days(yy) - yday;
		if (left <= room) begin
			yday += left;
		end else begin
			// Use up the starting year, then skip whole years while more remains than
			// the year holds. A remainder equal to the year length lands on Dec 31.
			left -= room;
			yy++;
			while (left > year_days(yy)) begin
				left -= year_days(yy);
				yy++;
			end
			yday = left;
		end
		mm = 1;
		while (mm < 12 && yday > mon_days(mm, yy)) begin
			yday -= mon_days(mm, yy);
			mm++;
		end
		r.day_out   = yday[4:0];
		r.month_out = mm[3:0];
		r.year_out  = yy[13:0];
		return r;
	endfunction

	// Mostly short idle stretches, now and then a long one; none in a calm phase.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// Date driver: one beat per queued date, held until taken.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		pend_t item;
		if (!arst_n) begin
			date_valid <= 1'b0;
		end else if (date_valid && !date_taken) begin
			// Beat still waiting for ready: keep valid and payload steady.
		end else if (gap_left != 0) begin
			date_valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_dates.size() != 0 &&
				(!pending_dates[0].hold || expected_results.size() == 0)) begin
			item = pending_dates.pop_front();
			date <= item.d;
			date_valid <= 1'b1;
			gap_left <= idle_len();
		end else begin
			date_valid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: ready drops at random, including while nothing is offered.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (stall_left != 0) begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			result_ready <= 1'b0;
			stall_left <= idle_len();
		end else begin
			result_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predicts on every accepted date beat and checks every result beat
	// against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		date_taken <= arst_n && date_valid && date_ready;
		if (arst_n) begin
			if (date_valid && date_ready)
				expected_results.push_back(shift_date(date, days_cfg));
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no date outstanding: %0d/%0d/%0d",
						result.day_out, result.month_out, result.year_out);
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (result.day_out !== want.day_out) begin
						$error("day_out: expected %0d, got %0d", want.day_out, result.day_out);
						fails++;
					end
					if (result.month_out !== want.month_out) begin
						$error("month_out: expected %0d, got %0d",
							want.month_out, result.month_out);
						fails++;
					end
					if (result.year_out !== want.year_out) begin
						$error("year_out: expected %0d, got %0d",
							want.year_out, result.year_out);
						fails++;
					end
					dates_checked++;
					outstanding--;
				end
			end
			if ((date_valid && date_ready) || (result_valid && result_ready) || psel)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog: a hung block shows up as a long run of cycles without any beat.
	initial begin
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$error("no beat for %0d cycles, %0d results still due", STALL_LIMIT, outstanding);
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_date(input int unsigned d, input int unsigned m,
			input int unsigned y, input bit hold);
		pend_t item;
		item.d.day_in   = d[4:0];
		item.d.month_in = m[3:0];
		item.d.year_in  = y[13:0];
		item.hold = hold;
		outstanding++;
		pending_dates.push_back(item);
	endtask

	// Waits at the falling edge, where every count from the rising edge has settled.
	task automatic wait_drained();
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic apb_write(input logic [15:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= DAYS_ADDR;
		pwdata <= {16'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		days_cfg = v;
	endtask

	task automatic apb_read_check(input logic [15:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= DAYS_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[15:0] !== v) begin
			$error("days_to_add: expected %0d, got %0d", v, prdata[15:0]);
			fails++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned p, k, d, m, y, r;
		logic [15:0] ofs;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The register must come out of reset at 45 days.
		apb_read_check(dad_pkg::DAYS_RESET);

		// Directed dates at the reset offset of 45 days.
		queue_date(1, 1, 1, 0);
		queue_date(31, 12, 9999, 0);
		queue_date(28, 2, 2000, 0);      // century leap year
		queue_date(28, 2, 1900, 0);      // century common year
		queue_date(29, 2, 2024, 0);
		queue_date(31, 12, 2023, 0);
		queue_date(16, 11, 1999, 0);     // lands exactly on Dec 31
		queue_date(17, 11, 1999, 0);     // lands exactly on Jan 1
		queue_date(0, 5, 2021, 0);       // day zero
		queue_date(31, 2, 2021, 1);      // day past month end; sent only once drained
		queue_date(31, 2, 2020, 0);
		queue_date(31, 11, 2020, 0);
		queue_date(15, 0, 2022, 0);      // month zero
		queue_date(10, 13, 2022, 0);     // months above December
		queue_date(10, 14, 2022, 0);
		queue_date(10, 15, 2022, 0);
		queue_date(1, 1, 0, 0);          // year zero
		queue_date(29, 2, 0, 0);
		queue_date(31, 12, 16383, 0);    // year runs past 14 bits and wraps
		queue_date(31, 15, 16383, 0);    // all input bits high
		queue_date(0, 0, 0, 0);          // all input bits low
		queue_date(1, 3, 2100, 0);
		queue_date(30, 4, 2400, 0);

		for (p = 0; p < PHASES; p++) begin
			// Offsets change only with nothing in flight.
			wait_drained();
			repeat (4) @(negedge clk);
			case (p)
				0:       ofs = 16'd0;
				1:       ofs = 16'd65535;
				2:       ofs = 16'd1;
				3:       ofs = 16'd306;
				4:       ofs = 16'd365;
				5:       ofs = 16'd366;
				6:       ofs = 16'd1461;
				7:       ofs = 16'd36524;
				8, 9, 10: ofs = 16'($urandom_range(0, 65535));
				default: ofs = 16'($urandom_range(0, 800));
			endcase
			apb_write(ofs);
			apb_read_check(ofs);
			calm = ($urandom_range(0, 3) == 0);

			for (k = 0; k < PER_PHASE; k++) begin
				r = $urandom_range(0, 99);
				if (r < 12) begin
					// Noise: any bit pattern the fields can carry.
					d = $urandom_range(0, 31);
					m = $urandom_range(0, 15);
					y = $urandom_range(0, 16383);
				end else begin
					// Valid calendar dates, weighted toward centuries, month ends and both ends of the year range.
					m = $urandom_range(1, 12);
					case ($urandom_range(0, 9))
						0:       y = 100 * $urandom_range(0, 163);
						1:       y = $urandom_range(16000, 16383);
						2:       y = $urandom_range(0, 20);
						default: y = $urandom_range(1, 9999);
					endcase
					if ($urandom_range(0, 3) == 0)
						d = mon_days(m, y);
					else
						d = $urandom_range(1, mon_days(m, y));
				end
				queue_date(d, m, y, $urandom_range(0, 199) == 0);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			fails++;
		end
		$display("Checked %0d dates over %0d day offsets from 0 to 65535,",
			dates_checked, PHASES + 1);
		$display("including leap, century, month-end and year-wrap dates under random stalls.");
		if (fails == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> date_add_days.f
+incdir+hdl
hdl/dad_pkg.sv
hdl/dad_ctrl.sv
hdl/dad_dp.sv
hdl/date_add_days.sv
tb/sv/tb_top.sv
